/* design/hrcc_pkg.sv */
// Types, constants and helper functions shared by the request completeness checker.
package hrcc_pkg;

	typedef enum logic [1:0] {
		LEN_SEARCH,
		LEN_SKIP_WS,
		LEN_VALUE,
		LEN_DONE
	} len_phase_t;

	typedef enum logic [2:0] {
		LINE_METHOD,
		LINE_WS,
		LINE_HEADER,
		LINE_BODY,
		LINE_FAIL
	} line_phase_t;

	localparam int KEY_LEN = 15;
	localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] HDR_END = 32'h0D0A_0D0A;
	localparam logic [2:0] MIN_METHOD_OFFSET = 3'd4;

	localparam logic [2:0] ST_COMPLETE_LEN   = 3'd0;
	localparam logic [2:0] ST_COMPLETE_NOLEN = 3'd1;
	localparam logic [2:0] ST_NO_HEADER_END  = 3'd2;
	localparam logic [2:0] ST_LENGTH_CUT     = 3'd3;
	localparam logic [2:0] ST_BODY_SHORT     = 3'd4;

	// What the length scanner reports after taking the current byte.
	typedef struct packed {
		logic        done;
		logic        pending;
		logic [30:0] value;
	} len_view_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/hrcc_if.sv */
// Valid/ready channel interfaces for request bytes and completeness results.
interface hrcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrcc_out_if;
	logic        valid;
	logic        ready;
	logic        incomplete;
	logic [2:0]  status;
	logic [30:0] content_length;
	logic [31:0] body_bytes;

	modport source (output valid, output incomplete, output status, output content_length,
		output body_bytes, input ready);
	modport sink (input valid, input incomplete, input status, input content_length,
		input body_bytes, output ready);
endinterface

/* design/hrcc_len_scan.sv */
// Content-length key matcher and decimal value parser.
module hrcc_len_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clear,
	input  logic [7:0]         data_byte,
	output hrcc_pkg::len_view_t view
);
	import hrcc_pkg::*;

	len_phase_t  phase_q, phase_d;
	logic [3:0]  key_q, key_d;
	logic [30:0] value_q, value_d;
	logic        open_q, open_d;

	logic [7:0]  lc;
	logic        ws;
	logic        digit;
	logic        take_value;
	logic [34:0] ext;
	logic [34:0] acc;

	always_comb begin
		lc = to_lower(data_byte);
		ws = is_ws(data_byte);
		digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		ext = {4'b0, value_q};
		acc = (ext << 3) + (ext << 1) + {31'b0, data_byte[3:0]};
		take_value = (phase_q == LEN_VALUE) || (phase_q == LEN_SKIP_WS && !ws);

		phase_d = phase_q;
		key_d = key_q;
		value_d = value_q;
		open_d = open_q;

		if (phase_q == LEN_SEARCH) begin
			if (lc == key_char(key_q)) begin
				if (key_q == 4'(KEY_LEN - 1)) begin
					phase_d = LEN_SKIP_WS;
					key_d = 4'd0;
				end else begin
					key_d = key_q + 4'd1;
				end
			end else begin
				// The mismatching byte may itself start a new key.
				key_d = (lc == key_char(4'd0)) ? 4'd1 : 4'd0;
			end
		end

		if (take_value) begin
			phase_d = LEN_VALUE;
			if (ws) begin
				phase_d = LEN_DONE;
			end else if (open_q && digit) begin
				value_d = (acc > {4'b0, LEN_MAX}) ? LEN_MAX : acc[30:0];
			end else begin
				open_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LEN_SEARCH;
			key_q <= 4'd0;
			value_q <= 31'd0;
			open_q <= 1'b1;
		end else if (clear) begin
			phase_q <= LEN_SEARCH;
			key_q <= 4'd0;
			value_q <= 31'd0;
			open_q <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			key_q <= key_d;
			value_q <= value_d;
			open_q <= open_d;
		end
	end

	assign view.done = (phase_d == LEN_DONE);
	assign view.pending = (phase_d != LEN_SEARCH) || (key_d != 4'd0);
	assign view.value = value_d;

endmodule

/* design/http_request_completeness_check_unit.sv */
// Top level of the HTTP request completeness checker.
// Usage:
// Request bytes enter on the req channel, one per transaction, with last_byte
// set on the final byte received so far. Only that final byte produces a
// transaction on the res channel, giving incomplete, status, the parsed
// content length and the number of body bytes seen after the blank line.
// Throughput is one byte per cycle, save where a last byte waits on a held
// result: each byte is held in an input register, the scanners update from
// it, and on a last byte the result is written to an output register. A
// waiting result does not stop non-final bytes; a second last byte waits in
// the input register until the receiver takes the result.
// After each last byte all scanner state returns to its reset value, so the
// next byte starts a new request. Reset (arst_n low) clears all scanner state
// and drops both valid flags. COUNT_WIDTH sets the body counter width; the
// reported body_bytes saturates at 32 bits.
module http_request_completeness_check_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input logic     clk,
	input logic     arst_n,
	hrcc_in_if.sink   req,
	hrcc_out_if.source res
);
	import hrcc_pkg::*;

	localparam int BW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       finish;

	logic        out_valid_q;
	logic        incomplete_q;
	logic [2:0]  status_q;
	logic [30:0] length_q;
	logic [31:0] body_q;

	line_phase_t            line_q, line_d;
	logic [2:0]             off_q, off_d;
	logic [23:0]            recent_q;
	logic [31:0]            window;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   ws;

	len_view_t   view;
	logic [BW-1:0] count_ext;
	logic [BW-1:0] len_ext;
	logic        inc_d;
	logic [2:0]  st_d;
	logic [30:0] len_d;
	logic [31:0] body_d;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign finish = advance && last_s1;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			byte_s1 <= req.data_byte;
			last_s1 <= req.last_byte;
		end
	end

	hrcc_len_scan u_len_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.clear     (finish),
		.data_byte (byte_s1),
		.view      (view)
	);

	// Request line and header-end scanner, with the body byte counter.
	always_comb begin
		ws = is_ws(byte_s1);
		window = {recent_q, byte_s1};
		line_d = line_q;
		count_d = count_q;
		case (line_q)
			LINE_METHOD: begin
				if (ws) line_d = LINE_WS;
			end
			LINE_WS: begin
				if (!ws) line_d = (off_q >= MIN_METHOD_OFFSET) ? LINE_HEADER : LINE_FAIL;
			end
			LINE_HEADER: begin
				if (window == HDR_END) line_d = LINE_BODY;
			end
			LINE_BODY: begin
				if (count_q != {COUNT_WIDTH{1'b1}}) count_d = count_q + COUNT_WIDTH'(1);
			end
			default: begin
				line_d = line_q;
			end
		endcase
		off_d = (off_q < MIN_METHOD_OFFSET) ? off_q + 3'd1 : off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_METHOD;
			off_q <= 3'd0;
			recent_q <= 24'd0;
			count_q <= '0;
		end else if (finish) begin
			line_q <= LINE_METHOD;
			off_q <= 3'd0;
			recent_q <= 24'd0;
			count_q <= '0;
		end else if (advance) begin
			line_q <= line_d;
			off_q <= off_d;
			recent_q <= window[23:0];
			count_q <= count_d;
		end
	end

	// Result from the state as it stands after the final byte.
	always_comb begin
		count_ext = BW'(count_d);
		len_ext = BW'(view.value);
		inc_d = 1'b1;
		st_d = ST_NO_HEADER_END;
		len_d = 31'd0;
		body_d = 32'd0;
		if (line_d == LINE_BODY) begin
			body_d = (count_ext > BW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : count_ext[31:0];
			if (view.done) begin
				len_d = view.value;
				inc_d = count_ext < len_ext;
				st_d = inc_d ? ST_BODY_SHORT : ST_COMPLETE_LEN;
			end else if (view.pending) begin
				st_d = ST_LENGTH_CUT;
			end else begin
				inc_d = 1'b0;
				st_d = ST_COMPLETE_NOLEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			incomplete_q <= inc_d;
			status_q <= st_d;
			length_q <= len_d;
			body_q <= body_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.incomplete = incomplete_q;
	assign res.status = status_q;
	assign res.content_length = length_q;
	assign res.body_bytes = body_q;

endmodule
